// ===== rtl/twv_pkg.sv =====
`timescale 1ns / 1ps

package twv_pkg;

  localparam int PHASE_W   = 21;
  localparam int IDX_MSB   = 20;
  localparam int IDX_LSB   = 16;
  localparam int PERIOD_W  = 13;
  localparam int LEVEL_W   = 4;
  localparam int SHAPE_W   = 3;
  localparam int CTL_W     = 8;
  localparam int OFFS_W    = 12;
  localparam int WAVE_AW   = 9;
  localparam int WAVE_DEPTH = 512;
  localparam int NIB_W     = 4;
  localparam int SAMPLE_W  = 16;
  localparam int TERM_W    = 9;
  localparam int MIX_SHIFT = 7;

  localparam logic [PERIOD_W-1:0] PERIOD_FULL = 13'h1000;
  localparam logic signed [NIB_W:0] NIB_BIAS  = 5'sd8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TERM_W-1:0]   term_t;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CTL_A   = 3'd1,
    OP_CTL_B   = 3'd2,
    OP_PITCH_A = 3'd3,
    OP_PITCH_B = 3'd4,
    OP_KEY_A   = 3'd5,
    OP_KEY_B   = 3'd6,
    OP_WAVE    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADV,
    ST_RD_A,
    ST_RD_B,
    ST_MIX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic ld_ctl_a;
    logic ld_ctl_b;
    logic ld_pitch_a;
    logic ld_pitch_b;
    logic key_a;
    logic key_b;
    logic wave_wr;
    logic div_step;
    logic advance;
    logic rd_b_sel;
    logic cap_a;
    logic mix;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/twv_ram.sv =====
`timescale 1ns / 1ps

module twv_ram #(
  parameter int W     = 4,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/twv_ctrl.sv =====
`timescale 1ns / 1ps

module twv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  twv_pkg::op_t      in_operation,
  input  twv_pkg::status_t  status,
  output twv_pkg::cmd_t     cmd
);

  import twv_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_TICK:  state_nxt = ST_ADV;
            OP_KEY_A: state_nxt = ST_DIV;
            OP_KEY_B: state_nxt = ST_DIV;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADV:  state_nxt = ST_RD_A;
      ST_RD_A: state_nxt = ST_RD_B;
      ST_RD_B: state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_CTL_A:   cmd.ld_ctl_a   = 1'b1;
            OP_CTL_B:   cmd.ld_ctl_b   = 1'b1;
            OP_PITCH_A: cmd.ld_pitch_a = 1'b1;
            OP_PITCH_B: cmd.ld_pitch_b = 1'b1;
            OP_KEY_A:   cmd.key_a      = 1'b1;
            OP_KEY_B:   cmd.key_b      = 1'b1;
            OP_WAVE:    cmd.wave_wr    = 1'b1;
            default:    cmd = '0;
          endcase
        end
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_ADV:  cmd.advance  = 1'b1;
      ST_RD_A: cmd.rd_b_sel = 1'b0;
      ST_RD_B: begin
        cmd.rd_b_sel = 1'b1;
        cmd.cap_a    = 1'b1;
      end
      ST_MIX:  cmd.mix = 1'b1;
      ST_OUT:  cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/twv_dp.sv =====
`timescale 1ns / 1ps

module twv_dp #(
  parameter int PHASE_SCALE_BITS = 21
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  twv_pkg::cmd_t                   cmd,
  output twv_pkg::status_t                status,
  input  logic [twv_pkg::CTL_W-1:0]       in_control_byte,
  input  logic [twv_pkg::OFFS_W-1:0]      in_pitch_offset,
  input  logic [twv_pkg::WAVE_AW-1:0]     in_wave_address,
  input  logic [twv_pkg::NIB_W-1:0]       in_wave_nibble,
  output logic                            out_valid,
  input  logic                            out_ready,
  output twv_pkg::sample_t                out_mixed_sample
);

  import twv_pkg::*;

  localparam int QW    = PHASE_SCALE_BITS + 1;
  localparam int CNT_W = $clog2(QW);

  // voice state
  logic [PHASE_W-1:0]  phase_a_r, phase_b_r;
  logic [PHASE_W-1:0]  inc_a_r, inc_b_r;
  logic [PERIOD_W-1:0] period_a_r, period_b_r;
  logic [PERIOD_W-1:0] pend_a_r, pend_b_r;
  logic [LEVEL_W-1:0]  level_a_r, level_b_r;
  logic [SHAPE_W-1:0]  shape_a_r, shape_b_r;
  logic                act_a, act_b;

  // divider
  logic [PERIOD_W-1:0] div_d_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [PERIOD_W:0]   rem_sh;
  logic                rem_ge;
  logic [QW-1:0]       q_r, q_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic                div_voice_r;

  // mix path
  logic [WAVE_AW-1:0]  raddr;
  logic [NIB_W-1:0]    rdata;
  term_t               term_a_r;
  term_t               sum_r;
  logic                out_valid_r;
  sample_t             out_sample_r;

  function automatic term_t voice_term(logic [NIB_W-1:0] nib, logic [LEVEL_W-1:0] lvl,
                                       logic act);
    logic signed [NIB_W:0]   s;
    logic signed [LEVEL_W:0] l;
    s = $signed({1'b0, nib}) - NIB_BIAS;
    l = $signed({1'b0, lvl});
    return act ? term_t'(TERM_W'(s) * TERM_W'(l)) : '0;
  endfunction

  assign act_a = (level_a_r != '0) && (period_a_r != '0);
  assign act_b = (level_b_r != '0) && (period_b_r != '0);

  // restoring division of 2^PHASE_SCALE_BITS, one quotient bit a cycle
  assign rem_sh = {rem_r, (cnt_r == '0)};
  assign rem_ge = rem_sh >= {1'b0, div_d_r};
  assign q_nxt  = {q_r[QW-2:0], rem_ge};

  assign status.div_done = (cnt_r == CNT_W'(QW - 1));
  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_a_r  <= '0;
      phase_b_r  <= '0;
      period_a_r <= '0;
      period_b_r <= '0;
      pend_a_r   <= '0;
      pend_b_r   <= '0;
      level_a_r  <= '0;
      level_b_r  <= '0;
      shape_a_r  <= '0;
      shape_b_r  <= '0;
    end else begin
      if (cmd.ld_ctl_a) begin
        level_a_r <= in_control_byte[LEVEL_W-1:0];
        shape_a_r <= in_control_byte[CTL_W-1 -: SHAPE_W];
      end
      if (cmd.ld_ctl_b) begin
        level_b_r <= in_control_byte[LEVEL_W-1:0];
        shape_b_r <= in_control_byte[CTL_W-1 -: SHAPE_W];
      end
      if (cmd.ld_pitch_a) begin
        pend_a_r <= PERIOD_FULL - {1'b0, in_pitch_offset};
      end
      if (cmd.ld_pitch_b) begin
        pend_b_r <= PERIOD_FULL - {1'b0, in_pitch_offset};
      end
      if (cmd.key_a) begin
        period_a_r <= pend_a_r;
      end
      if (cmd.key_b) begin
        period_b_r <= pend_b_r;
      end
      if (cmd.advance && act_a) begin
        phase_a_r <= phase_a_r + inc_a_r;
      end
      if (cmd.advance && act_b) begin
        phase_b_r <= phase_b_r + inc_b_r;
      end
    end
  end

  // divider and increment registers; the increment is only read while the
  // period is nonzero, and every key write refreshes it
  always_ff @(posedge clk) begin
    if (cmd.key_a || cmd.key_b) begin
      div_d_r     <= cmd.key_a ? pend_a_r : pend_b_r;
      div_voice_r <= cmd.key_b;
      rem_r       <= '0;
      q_r         <= '0;
      cnt_r       <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? PERIOD_W'(rem_sh - {1'b0, div_d_r}) : PERIOD_W'(rem_sh);
      q_r   <= q_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
      if (status.div_done) begin
        if (div_voice_r) begin
          inc_b_r <= PHASE_W'(q_nxt);
        end else begin
          inc_a_r <= PHASE_W'(q_nxt);
        end
      end
    end
  end

  assign raddr = cmd.rd_b_sel ? {1'b1, shape_b_r, phase_b_r[IDX_MSB:IDX_LSB]}
                              : {1'b0, shape_a_r, phase_a_r[IDX_MSB:IDX_LSB]};

  twv_ram #(
    .W     (NIB_W),
    .DEPTH (WAVE_DEPTH)
  ) u_wave (
    .clk   (clk),
    .we    (cmd.wave_wr),
    .waddr (in_wave_address),
    .wdata (in_wave_nibble),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      term_a_r <= voice_term(rdata, level_a_r, act_a);
    end
    if (cmd.mix) begin
      sum_r <= term_a_r + voice_term(rdata, level_b_r, act_b);
    end
    if (cmd.out_load) begin
      out_sample_r <= $signed({sum_r, {MIX_SHIFT{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_sample_r;

endmodule

// ===== rtl/two_voice_wavetable_sound_generator_unit.sv =====
`timescale 1ns / 1ps

// Two-voice wavetable sound generator.
// Input channel (in_valid/in_ready): one beat per operation. Control, pitch and
// wave-load beats update state in the accept cycle and produce no output.
// A key beat copies the pending period and then runs a serial restoring divider
// that computes the phase increment floor(2^PHASE_SCALE_BITS / period), one
// quotient bit per cycle. A tick beat steps through the sequencer: advance both
// phases, read voice A then voice B from the 512 x 4 wave RAM (one read port,
// registered read), mix, then load the output register, which raises out_valid.
// A new beat is accepted only once those steps are done, so ticks do not overlap.
// Result channel (out_valid/out_ready): one beat per tick holding the mixed
// sample, sum over voices of (nibble - 8) * volume, times 128.
// The output register parts the channels: the next operation is accepted while
// a finished sample waits; a second tick stalls in its last step until the
// waiting beat is taken. Input is held off (in_ready low) while busy.
// Reset (rst_n low, synchronous) clears phases, periods, volumes, shape selects
// and the output valid; wave RAM contents are undefined until loaded.
module two_voice_wavetable_sound_generator_unit #(
  parameter int PHASE_SCALE_BITS = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_operation,
  input  logic [twv_pkg::CTL_W-1:0]     in_control_byte,
  input  logic [twv_pkg::OFFS_W-1:0]    in_pitch_offset,
  input  logic [twv_pkg::WAVE_AW-1:0]   in_wave_address,
  input  logic [twv_pkg::NIB_W-1:0]     in_wave_nibble,
  output logic                          out_valid,
  input  logic                          out_ready,
  output twv_pkg::sample_t              out_mixed_sample
);

  import twv_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: decodes the beat and steps the divider and mix phases
  twv_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (op_t'(in_operation)),
    .status       (status),
    .cmd          (cmd)
  );

  // voice registers, divider, wave RAM and output register
  twv_dp #(
    .PHASE_SCALE_BITS (PHASE_SCALE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_control_byte  (in_control_byte),
    .in_pitch_offset  (in_pitch_offset),
    .in_wave_address  (in_wave_address),
    .in_wave_nibble   (in_wave_nibble),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mixed_sample (out_mixed_sample)
  );

endmodule

// ===== bench/twv_mix_checker.sv =====
`timescale 1ns / 1ps

module twv_mix_checker #(
  parameter int PHASE_SCALE_BITS = 21
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [2:0]                  in_operation,
  input  logic [twv_pkg::CTL_W-1:0]   in_control_byte,
  input  logic [twv_pkg::OFFS_W-1:0]  in_pitch_offset,
  input  logic [twv_pkg::WAVE_AW-1:0] in_wave_address,
  input  logic [twv_pkg::NIB_W-1:0]   in_wave_nibble,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  twv_pkg::sample_t            out_mixed_sample,
  output int                          fail_count,
  output int                          samples_waiting,
  output int                          samples_checked
);

  import twv_pkg::*;

  logic [PHASE_W-1:0]  phase_acc   [2];
  logic [PERIOD_W-1:0] period_act  [2];
  logic [PERIOD_W-1:0] period_next [2];
  logic [LEVEL_W-1:0]  volume      [2];
  logic [SHAPE_W-1:0]  shape_sel   [2];
  logic [NIB_W-1:0]    tone_ram    [WAVE_DEPTH];
  sample_t             mix_q       [$];
  int                  fails   = 0;
  int                  checked = 0;

  // Advance one voice and return (nibble - 8) * volume; silent voices hold phase.
  function automatic int voice_contrib(input int v);
    logic [31:0]      step;
    logic [NIB_W-1:0] nib;
    if (volume[v] == '0 || period_act[v] == '0) return 0;
    step = (32'd1 << PHASE_SCALE_BITS) / 32'(period_act[v]);
    phase_acc[v] = PHASE_W'(phase_acc[v] + step);
    nib = tone_ram[{v[0], shape_sel[v], phase_acc[v][IDX_MSB:IDX_LSB]}];
    return (int'(nib) - 8) * int'(volume[v]);
  endfunction

  function automatic sample_t tick_mix();
    int total;
    total = voice_contrib(0);
    total += voice_contrib(1);
    total = total * (1 << MIX_SHIFT);
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    return sample_t'(total);
  endfunction

  always @(posedge clk) begin
    sample_t want;
    op_t     op;
    int      v;
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        phase_acc[i]   = '0;
        period_act[i]  = '0;
        period_next[i] = '0;
        volume[i]      = '0;
        shape_sel[i]   = '0;
      end
      mix_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (mix_q.size() == 0) begin
          $error("mixed_sample: no beat expected, actual %0d", out_mixed_sample);
          fails++;
        end else begin
          want = mix_q.pop_front();
          if (out_mixed_sample !== want) begin
            $error("mixed_sample: expected %0d, actual %0d", want, out_mixed_sample);
            fails++;
          end
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        op = op_t'(in_operation);
        case (op)
          OP_TICK: mix_q.push_back(tick_mix());
          OP_CTL_A, OP_CTL_B: begin
            v = (op == OP_CTL_B);
            volume[v]    = in_control_byte[3:0];
            shape_sel[v] = in_control_byte[7:5];
          end
          OP_PITCH_A, OP_PITCH_B: begin
            v = (op == OP_PITCH_B);
            period_next[v] = PERIOD_FULL - PERIOD_W'(in_pitch_offset);
          end
          OP_KEY_A, OP_KEY_B: begin
            v = (op == OP_KEY_B);
            period_act[v] = period_next[v];
          end
          default: tone_ram[in_wave_address] = in_wave_nibble;
        endcase
      end
    end
    fail_count      <= fails;
    samples_waiting <= mix_q.size();
    samples_checked <= checked;
  end

endmodule

// ===== bench/two_voice_wavetable_sound_generator_unit_tb.sv =====
`timescale 1ns / 1ps

module two_voice_wavetable_sound_generator_unit_tb;

  import twv_pkg::*;

  localparam int SCALE_BITS   = 21;
  localparam int RANDOM_BEATS = 1110;
  // Worst case: key beats run the serial divider, ticks the sequencer steps, plus
  // sender gaps and receiver stalls; roughly 1650 beats in all.
  localparam int CYCLE_LIMIT  = 400000;
  // Divider run plus tick pipeline, with margin.
  localparam int DRAIN_CYCLES = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [2:0]           in_operation;
  logic [CTL_W-1:0]     in_control_byte;
  logic [OFFS_W-1:0]    in_pitch_offset;
  logic [WAVE_AW-1:0]   in_wave_address;
  logic [NIB_W-1:0]     in_wave_nibble;
  logic                 out_valid;
  logic                 out_ready;
  sample_t              out_mixed_sample;

  int fail_count;
  int samples_waiting;
  int samples_checked;
  int cycle_count = 0;
  int beats_sent  = 0;
  int ticks_sent  = 0;
  int wave_writes = 0;
  // High during the stretch where neither side idles.
  bit steady      = 1'b0;

  two_voice_wavetable_sound_generator_unit #(
    .PHASE_SCALE_BITS(SCALE_BITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_control_byte  (in_control_byte),
    .in_pitch_offset  (in_pitch_offset),
    .in_wave_address  (in_wave_address),
    .in_wave_nibble   (in_wave_nibble),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mixed_sample (out_mixed_sample)
  );

  twv_mix_checker #(
    .PHASE_SCALE_BITS(SCALE_BITS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_control_byte  (in_control_byte),
    .in_pitch_offset  (in_pitch_offset),
    .in_wave_address  (in_wave_address),
    .in_wave_nibble   (in_wave_nibble),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mixed_sample (out_mixed_sample),
    .fail_count       (fail_count),
    .samples_waiting  (samples_waiting),
    .samples_checked  (samples_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel about 29% of cycles, except in the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 29);
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one beat. Fields the operation does not use carry random values so
  // every input bit toggles. arg_a is the control byte, the pitch offset or the
  // wave address; arg_b is the wave nibble.
  task automatic push_op(input op_t op, input int arg_a = 0, input int arg_b = 0);
    logic [CTL_W-1:0]   ctl;
    logic [OFFS_W-1:0]  offs;
    logic [WAVE_AW-1:0] addr;
    logic [NIB_W-1:0]   nib;
    ctl  = CTL_W'($urandom);
    offs = OFFS_W'($urandom);
    addr = WAVE_AW'($urandom);
    nib  = NIB_W'($urandom);
    case (op)
      OP_CTL_A, OP_CTL_B:     ctl  = CTL_W'(arg_a);
      OP_PITCH_A, OP_PITCH_B: offs = OFFS_W'(arg_a);
      OP_WAVE: begin
        addr = WAVE_AW'(arg_a);
        nib  = NIB_W'(arg_b);
      end
      default: ;
    endcase
    // Insert a random gap before the beat, skipped in the steady stretch.
    while (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_control_byte <= ctl;
    in_pitch_offset <= offs;
    in_wave_address <= addr;
    in_wave_nibble  <= nib;
    // Hold the beat until the block takes it.
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (op == OP_TICK) ticks_sent++;
    if (op == OP_WAVE) wave_writes++;
  endtask

  initial begin
    int  vsel;
    int  reps;
    int  start;
    bit  drained_once;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_TICK;
    in_control_byte = '0;
    in_pitch_offset = '0;
    in_wave_address = '0;
    in_wave_nibble  = '0;
    drained_once    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Both voices are silent after reset, so these ticks mix to zero before any wave entry is loaded.
    push_op(OP_TICK);
    push_op(OP_TICK);

    // Fill the whole wave store before any voice can read it. Shape 7 slices
    // of both voices hold all zeros and shape 6 slices all fifteens, so the
    // mix can be driven to both of its extremes.
    for (int a = 0; a < WAVE_DEPTH; a++) begin
      push_op(OP_WAVE, a,
              (a[7:5] == 3'd7) ? 0 : (a[7:5] == 3'd6) ? 15 : $urandom_range(15));
    end

    // Directed cases.
    push_op(OP_CTL_A, 8'hFF);     // full volume, shape 7; bit 4 set and ignored
    push_op(OP_KEY_A);            // pending period still zero: voice stays idle
    push_op(OP_TICK);
    push_op(OP_PITCH_A, 0);       // longest period, 4096
    push_op(OP_KEY_A);
    push_op(OP_TICK);
    push_op(OP_PITCH_A, 4095);    // period 1: the step is one full turn
    push_op(OP_KEY_A);
    push_op(OP_TICK);
    push_op(OP_CTL_B, 8'hEF);
    push_op(OP_PITCH_B, 4094);    // period 2: half a turn per tick
    push_op(OP_KEY_B);
    push_op(OP_TICK);             // both voices on zero nibbles: lowest mix
    push_op(OP_TICK);
    push_op(OP_CTL_A, 8'hCF);
    push_op(OP_CTL_B, 8'hCF);
    push_op(OP_TICK);             // both voices on fifteens: highest mix
    push_op(OP_CTL_A, 8'h10);     // volume zero silences voice A
    push_op(OP_TICK);
    push_op(OP_WAVE, 511, 15);
    push_op(OP_WAVE, 0, 0);
    push_op(OP_TICK);

    // Hold the sender until every sample is back.
    in_valid <= 1'b0;
    do @(posedge clk); while (samples_waiting != 0);

    // Random part: mostly voice setups followed by runs of ticks, the rest noise.
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      steady <= (beats_sent - start >= 400) && (beats_sent - start < 750);
      if (!drained_once && beats_sent - start >= 900) begin
        drained_once = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (samples_waiting != 0);
      end
      if ($urandom_range(99) < 80) begin
        vsel = $urandom_range(1);
        push_op(vsel ? OP_CTL_B : OP_CTL_A, $urandom_range(255));
        // Skip the pitch write now and then so a key reuses the pending period.
        if ($urandom_range(3) != 0) begin
          // Favor short periods so the phase walks through the slice quickly.
          push_op(vsel ? OP_PITCH_B : OP_PITCH_A,
                  $urandom_range(1) ? $urandom_range(4095) : $urandom_range(4095, 3584));
        end
        push_op(vsel ? OP_KEY_B : OP_KEY_A);
        if ($urandom_range(99) < 30) begin
          reps = $urandom_range(3, 1);
          repeat (reps) push_op(OP_WAVE, $urandom_range(511), $urandom_range(15));
        end
        reps = $urandom_range(12, 2);
        repeat (reps) push_op(OP_TICK);
      end else begin
        push_op(op_t'($urandom_range(7)), $urandom_range(4095), $urandom_range(15));
      end
    end

    // Drain: wait for the last sample, then let any divider run finish.
    in_valid <= 1'b0;
    do @(posedge clk); while (samples_waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats (%0d ticks, %0d wave writes); checked %0d mixed samples.",
             beats_sent, ticks_sent, wave_writes, samples_checked);
    $display("Covered idle and zero-period voices, periods 1 to 4096, both mix extremes.");
    if (fail_count == 0 && samples_waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/twv_pkg.sv
rtl/twv_ram.sv
rtl/twv_ctrl.sv
rtl/twv_dp.sv
rtl/two_voice_wavetable_sound_generator_unit.sv
bench/twv_mix_checker.sv
bench/two_voice_wavetable_sound_generator_unit_tb.sv
